// File: rtl/ptu_pkg.sv
// Shared widths and fixed-point constants of the trajectory unwrap block.
`default_nettype none
package ptu_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned BOX_W    = 31;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned AXES     = 3;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned MAX_PARTICLES = 4096;

  localparam logic signed [DATA_W-1:0] FIX_ONE       = DATA_W'(64'sd1 << FRAC_BITS);
  localparam logic signed [DATA_W-1:0] FIX_MINUS_ONE = -FIX_ONE;
  localparam logic signed [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] NEG_MAX = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic signed [DATA_W-1:0] fix_t;

endpackage
`default_nettype wire

// File: rtl/ptu_ram.sv
// Simple dual-port RAM with registered read.
`default_nettype none
module ptu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/periodic_trajectory_unwrap_core.sv
// Periodic-boundary trajectory unwrap: one particle position word in, one unwrapped word out.
//
// Each input word carries one particle's raw Q16.16 position. The block looks up the
// particle's previous raw and unwrapped positions in two on-chip RAMs (one row of three
// axes per particle), reduces the frame-to-frame step to its minimum image on every
// periodic axis, and writes the new positions back. An item passes in turn through folding
// the particle index into range (two compare-subtract steps a cycle), one RAM read and
// its read-latency state, the three parallel restoring dividers that give the remainder
// for the quotient rounded half to even, and write-back. The block takes no new word until
// the previous one has been written back. The result register frees the input side, so a
// new word is taken while the previous result is still stalled. Positions of a particle
// that was never seeded with a first-frame word are undefined.
`default_nettype none
module periodic_trajectory_unwrap_core #(
  parameter int unsigned MAX_PARTICLES = ptu_pkg::MAX_PARTICLES
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [ptu_pkg::IDX_W-1:0]          in_particle_index,
  input  wire logic                               in_first_frame,
  input  wire logic                               in_new_dataset,
  input  wire logic signed [ptu_pkg::DATA_W-1:0]  in_pos_x,
  input  wire logic signed [ptu_pkg::DATA_W-1:0]  in_pos_y,
  input  wire logic signed [ptu_pkg::DATA_W-1:0]  in_pos_z,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [ptu_pkg::DATA_W-1:0]       out_unwrapped_x,
  output logic signed [ptu_pkg::DATA_W-1:0]       out_unwrapped_y,
  output logic signed [ptu_pkg::DATA_W-1:0]       out_unwrapped_z,
  output logic signed [ptu_pkg::DATA_W-1:0]       out_bound_min_x,
  output logic signed [ptu_pkg::DATA_W-1:0]       out_bound_min_y,
  output logic signed [ptu_pkg::DATA_W-1:0]       out_bound_min_z,
  output logic signed [ptu_pkg::DATA_W-1:0]       out_bound_max_x,
  output logic signed [ptu_pkg::DATA_W-1:0]       out_bound_max_y,
  output logic signed [ptu_pkg::DATA_W-1:0]       out_bound_max_z,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [ptu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ptu_pkg::BOX_W-1:0]          cfg_data
);

  localparam int unsigned DW    = ptu_pkg::DATA_W;
  localparam int unsigned BW    = ptu_pkg::BOX_W;
  localparam int unsigned IW    = ptu_pkg::IDX_W;
  localparam int unsigned NAX   = ptu_pkg::AXES;
  localparam int unsigned AW    = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int unsigned MW    = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned CW    = IW + MW;
  localparam int unsigned KW    = $clog2(IW);
  localparam int unsigned DIV_STEPS = DW + 1;
  localparam int unsigned SW    = $clog2(DIV_STEPS + 1);
  localparam int unsigned ROW_W = DW * NAX;

  localparam logic [CW-1:0] MAX_WIDE = CW'(MAX_PARTICLES);

  localparam logic [ptu_pkg::CFG_IDX_W-1:0] REG_BOX_WIDTH  = 3'd0;
  localparam logic [ptu_pkg::CFG_IDX_W-1:0] REG_BOX_HEIGHT = 3'd1;
  localparam logic [ptu_pkg::CFG_IDX_W-1:0] REG_BOX_DEPTH  = 3'd2;
  localparam logic [ptu_pkg::CFG_IDX_W-1:0] REG_PERIODIC   = 3'd3;
  localparam logic [ptu_pkg::CFG_IDX_W-1:0] REG_BOUNDS_EN  = 3'd4;
  localparam logic [ptu_pkg::CFG_IDX_W-1:0] REG_PROJECTION = 3'd5;

  localparam logic [1:0] PROJ_X = 2'd1;
  localparam logic [1:0] PROJ_Y = 2'd2;
  localparam logic [1:0] PROJ_Z = 2'd3;
  localparam logic [1:0] PROJ_CODE [NAX] = '{PROJ_X, PROJ_Y, PROJ_Z};

  localparam logic [BW-1:0] BOX_RESET = BW'(64'd1 << ptu_pkg::FRAC_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_RD,
    ST_LAT,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t state_r;

  // configuration
  logic [BW-1:0] box_r [NAX];
  logic [2:0]    periodic_r;
  logic          bounds_en_r;
  logic [1:0]    proj_r;

  // item
  logic [IW-1:0]      idx_r;
  logic [KW-1:0]      mod_k_r;
  logic               first_r;
  logic               fresh_r;
  ptu_pkg::fix_t      pos_r [NAX];

  // dividers
  logic [SW-1:0]      div_cnt_r;
  logic [DW:0]        dvd_r [NAX];
  logic [BW-1:0]      rem_r [NAX];
  logic               q0_r  [NAX];
  logic signed [DW:0] d_r   [NAX];
  logic               dneg_r[NAX];

  // bounds and result
  ptu_pkg::fix_t      run_min_r [NAX];
  ptu_pkg::fix_t      run_max_r [NAX];
  logic               out_valid_r;
  ptu_pkg::fix_t      o_unw_r [NAX];
  ptu_pkg::fix_t      o_min_r [NAX];
  ptu_pkg::fix_t      o_max_r [NAX];

  // RAM ports
  logic [AW-1:0]      ram_addr;
  logic               ram_we;
  logic [ROW_W-1:0]   raw_wdata;
  logic [ROW_W-1:0]   unw_wdata;
  logic [ROW_W-1:0]   raw_rdata;
  logic [ROW_W-1:0]   unw_rdata;

  // combinational
  logic               out_free;
  logic [IW-1:0]      idx_nxt;
  logic [DW:0]        t_div   [NAX];
  logic               t_ge    [NAX];
  logic signed [DW:0] d_nxt   [NAX];
  logic [DW:0]        two_ar  [NAX];
  logic               round_up[NAX];
  logic signed [DW:0] mag     [NAX];
  logic signed [DW:0] step    [NAX];
  logic signed [DW+1:0] sum   [NAX];
  ptu_pkg::fix_t      sat     [NAX];
  ptu_pkg::fix_t      unw     [NAX];
  ptu_pkg::fix_t      prev_raw[NAX];
  ptu_pkg::fix_t      prev_unw[NAX];
  ptu_pkg::fix_t      min_base[NAX];
  ptu_pkg::fix_t      max_base[NAX];
  ptu_pkg::fix_t      min_nxt [NAX];
  ptu_pkg::fix_t      max_nxt [NAX];

  function automatic logic [IW-1:0] mod_step(input logic [IW-1:0] v, input logic [KW-1:0] k);
    logic [CW-1:0] wide;
    logic [CW-1:0] sub;
    wide = CW'(v) >> k;
    sub  = MAX_WIDE << k;
    if (wide >= MAX_WIDE) begin
      return v - sub[IW-1:0];
    end
    return v;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign ram_addr  = idx_r[AW-1:0];
  assign ram_we    = (state_r == ST_FIN) && out_free;

  always_comb begin
    idx_nxt = mod_step(idx_r, mod_k_r);
    if (mod_k_r != '0) begin
      idx_nxt = mod_step(idx_nxt, mod_k_r - KW'(1));
    end
  end

  always_comb begin
    for (int k = 0; k < NAX; k++) begin
      prev_raw[k] = raw_rdata[k*DW +: DW];
      prev_unw[k] = unw_rdata[k*DW +: DW];
      d_nxt[k]    = (DW+1)'(pos_r[k]) - (DW+1)'(prev_raw[k]);

      t_div[k] = {1'b0, rem_r[k], dvd_r[k][DW]};
      t_ge[k]  = t_div[k] >= (DW+1)'(box_r[k]);

      two_ar[k]   = {1'b0, rem_r[k], 1'b0};
      round_up[k] = (two_ar[k] > (DW+1)'(box_r[k]))
                 || ((two_ar[k] == (DW+1)'(box_r[k])) && q0_r[k]);
      mag[k] = round_up[k] ? $signed((DW+1)'(rem_r[k])) - $signed((DW+1)'(box_r[k]))
                           : $signed((DW+1)'(rem_r[k]));
      if (box_r[k] == '0) begin
        step[k] = d_r[k];
      end else begin
        step[k] = dneg_r[k] ? -mag[k] : mag[k];
      end
      sum[k] = (DW+2)'(prev_unw[k]) + (DW+2)'(step[k]);
      if (sum[k] > (DW+2)'(ptu_pkg::POS_MAX)) begin
        sat[k] = ptu_pkg::POS_MAX;
      end else if (sum[k] < (DW+2)'(ptu_pkg::NEG_MAX)) begin
        sat[k] = ptu_pkg::NEG_MAX;
      end else begin
        sat[k] = sum[k][DW-1:0];
      end
      unw[k] = (first_r || !periodic_r[k]) ? pos_r[k] : sat[k];

      min_base[k] = fresh_r ? ptu_pkg::POS_MAX : run_min_r[k];
      max_base[k] = fresh_r ? ptu_pkg::NEG_MAX : run_max_r[k];
      min_nxt[k]  = (bounds_en_r && (unw[k] < min_base[k])) ? unw[k] : min_base[k];
      max_nxt[k]  = (bounds_en_r && (unw[k] > max_base[k])) ? unw[k] : max_base[k];

      raw_wdata[k*DW +: DW] = pos_r[k];
      unw_wdata[k*DW +: DW] = unw[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      periodic_r  <= 3'b111;
      bounds_en_r <= 1'b1;
      proj_r      <= '0;
      for (int k = 0; k < NAX; k++) begin
        box_r[k]     <= BOX_RESET;
        run_min_r[k] <= ptu_pkg::POS_MAX;
        run_max_r[k] <= ptu_pkg::NEG_MAX;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BOX_WIDTH:  box_r[0]    <= cfg_data;
          REG_BOX_HEIGHT: box_r[1]    <= cfg_data;
          REG_BOX_DEPTH:  box_r[2]    <= cfg_data;
          REG_PERIODIC:   periodic_r  <= cfg_data[2:0];
          REG_BOUNDS_EN:  bounds_en_r <= cfg_data[0];
          REG_PROJECTION: proj_r      <= cfg_data[1:0];
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            idx_r    <= in_particle_index;
            first_r  <= in_first_frame;
            fresh_r  <= in_new_dataset;
            pos_r[0] <= in_pos_x;
            pos_r[1] <= in_pos_y;
            pos_r[2] <= in_pos_z;
            mod_k_r  <= KW'(IW - 1);
            state_r  <= ST_MOD;
          end
        end
        ST_MOD: begin
          idx_r <= idx_nxt;
          if (mod_k_r <= KW'(1)) begin
            state_r <= ST_RD;
          end else begin
            mod_k_r <= mod_k_r - KW'(2);
          end
        end
        ST_RD: begin
          state_r <= ST_LAT;
        end
        ST_LAT: begin
          for (int k = 0; k < NAX; k++) begin
            d_r[k]    <= d_nxt[k];
            dneg_r[k] <= d_nxt[k][DW];
            dvd_r[k]  <= d_nxt[k][DW] ? -d_nxt[k] : d_nxt[k];
            rem_r[k]  <= '0;
            q0_r[k]   <= 1'b0;
          end
          div_cnt_r <= '0;
          state_r   <= ST_DIV;
        end
        ST_DIV: begin
          for (int k = 0; k < NAX; k++) begin
            rem_r[k] <= t_ge[k] ? BW'(t_div[k] - (DW+1)'(box_r[k])) : BW'(t_div[k]);
            q0_r[k]  <= t_ge[k];
            dvd_r[k] <= {dvd_r[k][DW-1:0], 1'b0};
          end
          div_cnt_r <= div_cnt_r + SW'(1);
          if (div_cnt_r == SW'(DIV_STEPS - 1)) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            for (int k = 0; k < NAX; k++) begin
              run_min_r[k] <= min_nxt[k];
              run_max_r[k] <= max_nxt[k];
              if (proj_r == PROJ_CODE[k]) begin
                o_unw_r[k] <= '0;
                o_min_r[k] <= ptu_pkg::FIX_MINUS_ONE;
                o_max_r[k] <= ptu_pkg::FIX_ONE;
              end else begin
                o_unw_r[k] <= unw[k];
                o_min_r[k] <= min_nxt[k];
                o_max_r[k] <= max_nxt[k];
              end
            end
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  ptu_ram #(
    .WIDTH(ROW_W),
    .DEPTH(MAX_PARTICLES)
  ) u_raw_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_addr),
    .wdata(raw_wdata),
    .raddr(ram_addr),
    .rdata(raw_rdata)
  );

  ptu_ram #(
    .WIDTH(ROW_W),
    .DEPTH(MAX_PARTICLES)
  ) u_unw_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_addr),
    .wdata(unw_wdata),
    .raddr(ram_addr),
    .rdata(unw_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_unwrapped_x = o_unw_r[0];
  assign out_unwrapped_y = o_unw_r[1];
  assign out_unwrapped_z = o_unw_r[2];
  assign out_bound_min_x = o_min_r[0];
  assign out_bound_min_y = o_min_r[1];
  assign out_bound_min_z = o_min_r[2];
  assign out_bound_max_x = o_max_r[0];
  assign out_bound_max_y = o_max_r[1];
  assign out_bound_max_z = o_max_r[2];

endmodule
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the periodic trajectory unwrap core.
`timescale 1ns / 1ps
module testbench;
  import ptu_pkg::*;

  localparam int LIMIT  = 500000;
  localparam int SETTLE = 60;
  localparam int PHASES = 8;
  localparam int PHASE_WORDS = 125;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_WIDTH       = 0,
    REG_BOX_HEIGHT      = 1,
    REG_BOX_DEPTH       = 2,
    REG_PERIODIC_AXES   = 3,
    REG_BOUNDS_ENABLE   = 4,
    REG_PROJECTION_AXIS = 5,
    REG_SPARE           = 7
  } reg_e;

  typedef enum logic [1:0] {FLAT_NONE, FLAT_X, FLAT_Y, FLAT_Z} flat_e;

  localparam logic [AXES-1:0] ALL_AXES = '1;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic             first;
    logic             fresh;
    fix_t             pos[AXES];
  } word_t;

  // unwrapped x/y/z, min x/y/z, max x/y/z
  typedef struct {
    fix_t v[9];
  } result_t;

  typedef enum {ROW_WORD, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    word_t             w;
    reg_e              reg_idx;
    logic [BOX_W-1:0]  reg_val;
    bit                typed;
    result_t           res;
  } row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [IDX_W-1:0] in_particle_index = '0;
  logic in_first_frame = 1'b0;
  logic in_new_dataset = 1'b0;
  fix_t in_pos_x = '0;
  fix_t in_pos_y = '0;
  fix_t in_pos_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fix_t out_unwrapped_x, out_unwrapped_y, out_unwrapped_z;
  fix_t out_bound_min_x, out_bound_min_y, out_bound_min_z;
  fix_t out_bound_max_x, out_bound_max_y, out_bound_max_z;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BOX_W-1:0] cfg_data = '0;

  periodic_trajectory_unwrap_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_particle_index (in_particle_index),
    .in_first_frame    (in_first_frame),
    .in_new_dataset    (in_new_dataset),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_pos_z          (in_pos_z),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_unwrapped_x   (out_unwrapped_x),
    .out_unwrapped_y   (out_unwrapped_y),
    .out_unwrapped_z   (out_unwrapped_z),
    .out_bound_min_x   (out_bound_min_x),
    .out_bound_min_y   (out_bound_min_y),
    .out_bound_min_z   (out_bound_min_z),
    .out_bound_max_x   (out_bound_max_x),
    .out_bound_max_y   (out_bound_max_y),
    .out_bound_max_z   (out_bound_max_z),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // shadow of the block's registers and particle memory
  fix_t last_raw [MAX_PARTICLES][AXES];
  fix_t last_unw [MAX_PARTICLES][AXES];
  bit   seeded [MAX_PARTICLES];
  fix_t run_lo [AXES];
  fix_t run_hi [AXES];
  logic [BOX_W-1:0] box_ext [AXES];
  logic [AXES-1:0]  periodic_mask;
  logic             bounds_on;
  logic [1:0]       flat_axis;

  result_t pending_results[$];
  string field_name[9] = '{"unwrapped_x", "unwrapped_y", "unwrapped_z",
                           "bound_min_x", "bound_min_y", "bound_min_z",
                           "bound_max_x", "bound_max_y", "bound_max_z"};

  int  words_sent;
  int  results_seen;
  int  mismatches;
  int  reg_writes;
  int  rx_hold;
  int  cycle;
  bit  calm;

  function automatic int gap_draw();
    return calm ? 0 : int'($urandom_range(0, 12));
  endfunction

  // step minus box times the quotient rounded half to even
  function automatic longint nearest_image(longint d, longint b);
    longint q, r, ar;
    if (b <= 0) return d;
    q = d / b;
    r = d - q * b;
    ar = (r < 0) ? -r : r;
    if (2 * ar > b || (2 * ar == b && (q % 2) != 0))
      r -= (d < 0) ? -b : b;
    return r;
  endfunction

  function automatic fix_t clamp32(longint v);
    if (v > longint'(POS_MAX)) return POS_MAX;
    if (v < longint'(NEG_MAX)) return NEG_MAX;
    return fix_t'(v);
  endfunction

  function automatic result_t unwrap_predict(word_t w);
    result_t r;
    fix_t    u[AXES];
    longint  step;
    int      p;
    int      k;
    p = int'(w.idx) % MAX_PARTICLES;
    if (w.fresh) begin
      for (k = 0; k < AXES; k++) begin
        run_lo[k] = POS_MAX;
        run_hi[k] = NEG_MAX;
      end
    end
    for (k = 0; k < AXES; k++) begin
      if (w.first || !periodic_mask[k]) begin
        u[k] = w.pos[k];
      end else begin
        step = nearest_image(longint'(w.pos[k]) - longint'(last_raw[p][k]),
                             longint'(box_ext[k]));
        u[k] = clamp32(longint'(last_unw[p][k]) + step);
      end
      last_raw[p][k] = w.pos[k];
      last_unw[p][k] = u[k];
      if (bounds_on) begin
        if (u[k] < run_lo[k]) run_lo[k] = u[k];
        if (u[k] > run_hi[k]) run_hi[k] = u[k];
      end
    end
    if (w.first) seeded[p] = 1'b1;
    for (k = 0; k < AXES; k++) begin
      if (int'(flat_axis) == k + 1) begin
        r.v[k]     = '0;
        r.v[3 + k] = FIX_MINUS_ONE;
        r.v[6 + k] = FIX_ONE;
      end else begin
        r.v[k]     = u[k];
        r.v[3 + k] = run_lo[k];
        r.v[6 + k] = run_hi[k];
      end
    end
    return r;
  endfunction

  function automatic logic [BOX_W-1:0] pick_box();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 31'd1;
      2:       return {BOX_W{1'b1}};
      3, 4:    return 31'h0001_0000;
      5, 6:    return BOX_W'($urandom_range(1, 32'h0010_0000));
      default: return BOX_W'($urandom_range(1, 32'h7FFF_FFFF));
    endcase
  endfunction

  // next raw coordinate: mostly a wrapped walk, sometimes exact half-box steps, extreme values or noise
  function automatic fix_t next_coord(fix_t prev, logic [BOX_W-1:0] ext);
    longint b, s, x;
    int unsigned pick;
    b = longint'(ext);
    pick = $urandom_range(0, 19);
    if (pick < 3) return fix_t'($urandom);
    if (pick == 3) return ($urandom_range(0, 1) != 0) ? POS_MAX : NEG_MAX;
    if (b == 0)
      return fix_t'(longint'(prev) + longint'($urandom_range(0, 32'h0008_0000)) - 64'sd262144);
    if (pick == 4)
      return fix_t'(longint'(prev) + (b / 2) * longint'(2 * $urandom_range(0, 2) + 1)
                    * (($urandom_range(0, 1) != 0) ? 64'sd1 : -64'sd1));
    s = longint'($urandom_range(0, 32'(2 * b))) - b;
    x = (longint'(prev) + s) % b;
    if (x < 0) x += b;
    return fix_t'(x);
  endfunction

  function automatic row_t word_row(int idx, bit ff, bit nd, fix_t x, fix_t y, fix_t z);
    row_t r;
    r.kind     = ROW_WORD;
    r.w.idx    = IDX_W'(idx);
    r.w.first  = ff;
    r.w.fresh  = nd;
    r.w.pos[0] = x;
    r.w.pos[1] = y;
    r.w.pos[2] = z;
    r.reg_idx  = REG_BOX_WIDTH;
    r.reg_val  = '0;
    r.typed    = 1'b0;
    return r;
  endfunction

  function automatic row_t reg_row(reg_e idx, logic [BOX_W-1:0] val);
    row_t r;
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    r.typed   = 1'b0;
    return r;
  endfunction

  task automatic send_word(input word_t w, input bit typed, input result_t want);
    int gap;
    result_t r;
    gap = gap_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_particle_index <= w.idx;
    in_first_frame    <= w.first;
    in_new_dataset    <= w.fresh;
    in_pos_x          <= w.pos[0];
    in_pos_y          <= w.pos[1];
    in_pos_z          <= w.pos[2];
    do @(posedge clk); while (in_stall);
    r = unwrap_predict(w);
    pending_results.push_back(typed ? want : r);
    words_sent++;
  endtask

  task automatic write_reg(input reg_e idx, input logic [BOX_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BOX_WIDTH:       box_ext[0] = val;
      REG_BOX_HEIGHT:      box_ext[1] = val;
      REG_BOX_DEPTH:       box_ext[2] = val;
      REG_PERIODIC_AXES:   periodic_mask = val[AXES-1:0];
      REG_BOUNDS_ENABLE:   bounds_on = val[0];
      REG_PROJECTION_AXIS: flat_axis = val[1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    result_t got, want;
    int k;
    if (rst_n && out_valid && !out_stall) begin
      got.v = '{out_unwrapped_x, out_unwrapped_y, out_unwrapped_z,
                out_bound_min_x, out_bound_min_y, out_bound_min_z,
                out_bound_max_x, out_bound_max_y, out_bound_max_z};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result word with nothing outstanding, expected none, got %h %h %h",
                 $time, got.v[0], got.v[1], got.v[2]);
      end else begin
        want = pending_results.pop_front();
        for (k = 0; k < 9; k++) begin
          if (got.v[k] !== want.v[k]) begin
            mismatches++;
            $display("%0t: %s expected %h got %h", $time, field_name[k], want.v[k], got.v[k]);
          end
        end
      end
      rx_hold = gap_draw();
    end else if (rx_hold != 0) begin
      rx_hold--;
    end
    out_stall <= (rx_hold != 0);
  end

  initial begin : watchdog
    cycle = 0;
    while (cycle < LIMIT) begin
      @(posedge clk);
      cycle++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle,
             pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    row_t    plan[$];
    row_t    r;
    word_t   w;
    result_t none;
    int      pool[16];
    int      idx;
    int      ph;
    int      n;
    int      k;
    bit      in_regs;

    foreach (last_raw[i, j]) begin
      last_raw[i][j] = '0;
      last_unw[i][j] = '0;
    end
    foreach (seeded[i]) seeded[i] = 1'b0;
    for (k = 0; k < AXES; k++) begin
      run_lo[k]  = POS_MAX;
      run_hi[k]  = NEG_MAX;
      box_ext[k] = 31'h0001_0000;
    end
    periodic_mask = ALL_AXES;
    bounds_on     = 1'b1;
    flat_axis     = FLAT_NONE;
    calm          = 1'b0;
    rx_hold       = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: unit box, all axes periodic
    r = word_row(0, 1, 0, 32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000);
    r.typed = 1'b1;
    r.res.v = '{32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000,
                32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000,
                32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000};
    plan.push_back(r);
    // half-box steps, even and odd quotients
    plan.push_back(word_row(0, 0, 0, 32'h0001_4000, 32'hFFFD_8000, 32'h0003_8000));
    plan.push_back(word_row(0, 0, 0, 32'h0002_C000, 32'hFFFF_0000, 32'h0001_0000));
    plan.push_back(word_row(0, 0, 0, 32'h0000_0000, 32'h0000_E666, 32'hFFFF_8000));
    r = word_row(4095, 1, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    r.typed = 1'b1;
    r.res.v = '{POS_MAX, NEG_MAX, 32'h0, POS_MAX, NEG_MAX, 32'h0, POS_MAX, NEG_MAX, 32'h0};
    plan.push_back(r);
    plan.push_back(word_row(4095, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    plan.push_back(word_row(12'hAAA, 1, 0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F));
    plan.push_back(word_row(12'h555, 1, 1, 32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0));
    plan.push_back(word_row(12'hAAA, 0, 0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0));
    // widest box, zero box on y: saturation both ways, then stored saturated value
    plan.push_back(reg_row(REG_BOX_WIDTH, {BOX_W{1'b1}}));
    plan.push_back(reg_row(REG_BOX_HEIGHT, '0));
    plan.push_back(reg_row(REG_BOX_DEPTH, {BOX_W{1'b1}}));
    plan.push_back(word_row(1, 1, 0, 32'h7FFF_0000, 32'h4000_0000, 32'h8001_0000));
    plan.push_back(word_row(1, 0, 0, 32'hBFFF_0000, 32'h8000_0000, 32'h4001_0000));
    plan.push_back(word_row(1, 0, 0, 32'hBFFF_0000, 32'h8000_0000, 32'h4002_0000));
    // tiny boxes, y not periodic, bounds frozen, y flattened
    plan.push_back(reg_row(REG_BOX_WIDTH, 31'd1));
    plan.push_back(reg_row(REG_BOX_HEIGHT, 31'h0001_0000));
    plan.push_back(reg_row(REG_BOX_DEPTH, 31'h0000_8000));
    plan.push_back(reg_row(REG_PERIODIC_AXES, 31'd5));
    plan.push_back(reg_row(REG_BOUNDS_ENABLE, 31'd0));
    plan.push_back(reg_row(REG_PROJECTION_AXIS, FLAT_Y));
    r = word_row(2, 1, 1, 32'h0005_0000, 32'h0006_0000, 32'h0007_0000);
    r.typed = 1'b1;
    r.res.v = '{32'h0005_0000, 32'h0, 32'h0007_0000,
                POS_MAX, FIX_MINUS_ONE, POS_MAX,
                NEG_MAX, FIX_ONE, NEG_MAX};
    plan.push_back(r);
    plan.push_back(word_row(2, 0, 0, 32'h0005_1234, 32'h0006_8000, 32'h0007_4000));
    plan.push_back(word_row(0, 0, 0, 32'h0003_0000, 32'h0000_0000, 32'h0000_0000));
    plan.push_back(reg_row(REG_PERIODIC_AXES, 31'd0));
    plan.push_back(reg_row(REG_BOUNDS_ENABLE, 31'd1));
    plan.push_back(reg_row(REG_PROJECTION_AXIS, FLAT_X));
    plan.push_back(word_row(2, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000));
    plan.push_back(word_row(3, 1, 1, 32'hFFFF_0000, 32'h0002_0000, 32'hFFFD_0000));
    plan.push_back(reg_row(REG_PERIODIC_AXES, 31'd2));
    plan.push_back(reg_row(REG_PROJECTION_AXIS, FLAT_Z));
    plan.push_back(reg_row(REG_SPARE, {BOX_W{1'b1}}));
    plan.push_back(word_row(3, 0, 0, 32'h0000_8000, 32'h7FFF_0000, 32'h1234_5678));
    plan.push_back(word_row(4095, 0, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    plan.push_back(reg_row(REG_BOX_WIDTH, 31'h0001_0000));
    plan.push_back(reg_row(REG_BOX_HEIGHT, 31'h0001_0000));
    plan.push_back(reg_row(REG_BOX_DEPTH, 31'h0001_0000));
    plan.push_back(reg_row(REG_PERIODIC_AXES, ALL_AXES));
    plan.push_back(reg_row(REG_PROJECTION_AXIS, FLAT_NONE));
    plan.push_back(word_row(0, 0, 0, 32'h0003_8000, 32'h0000_8000, 32'hFFFF_8000));
    plan.push_back(word_row(1, 0, 1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));

    in_regs = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        if (!in_regs) drain();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
        in_regs = 1'b1;
      end else begin
        if (in_regs) cfg_valid <= 1'b0;
        in_regs = 1'b0;
        send_word(plan[i].w, plan[i].typed, plan[i].res);
      end
    end

    // a few busy particles plus the odd stray index
    pool[0] = 0;
    pool[1] = 4095;
    for (k = 2; k < 16; k++) pool[k] = $urandom_range(0, 4095);

    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      write_reg(REG_BOX_WIDTH, pick_box());
      write_reg(REG_BOX_HEIGHT, pick_box());
      write_reg(REG_BOX_DEPTH, pick_box());
      write_reg(REG_PERIODIC_AXES, BOX_W'($urandom_range(0, 7)));
      write_reg(REG_BOUNDS_ENABLE, BOX_W'($urandom_range(0, 3) != 0));
      write_reg(REG_PROJECTION_AXIS, BOX_W'($urandom_range(0, 3)));
      cfg_valid <= 1'b0;
      calm = (ph % 3 == 1);
      for (n = 0; n < PHASE_WORDS; n++) begin
        idx = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 4095))
                                          : pool[$urandom_range(0, 15)];
        w.idx   = IDX_W'(idx);
        w.first = !seeded[idx] || ($urandom_range(0, 29) == 0);
        w.fresh = ($urandom_range(0, 19) == 0);
        for (k = 0; k < AXES; k++) w.pos[k] = next_coord(last_raw[idx][k], box_ext[k]);
        send_word(w, 1'b0, none);
        if (ph == 2 && n == PHASE_WORDS / 2) drain();
      end
    end
    calm = 1'b0;
    drain();

    $display("%0d position words sent, %0d result words checked, %0d register writes",
             words_sent, results_seen, reg_writes);
    $display("covered minimum-image ties, saturation, zero and extreme boxes, projection");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ptu_pkg.sv
rtl/ptu_ram.sv
rtl/periodic_trajectory_unwrap_core.sv
test/testbench.sv
